@@ sv/psic_pkg.sv @@
// Shared types and constants for the packed symmetric inverse check.
package psic_pkg;

    localparam int VALUE_W   = 32;
    localparam int INDEX_W   = 8;
    localparam int SIZE_W    = 5;
    localparam int SUM_W     = 48;
    localparam int FRAC_BITS = 24;
    localparam int CHECK_W   = 58;

    localparam logic [SIZE_W-1:0] MATRIX_SIZE_RESET = 5'd16;
    localparam logic [SUM_W-1:0]  SUM_MAX = {SUM_W{1'b1}};

    // The off-diagonal sum times 10000 exceeds one exactly when it exceeds this count.
    localparam logic [SUM_W-1:0] OFF_LIMIT = SUM_W'((64'd1 << FRAC_BITS) / 64'd10000);

    localparam int DIAG_SCALE    = 1000;
    localparam int DIAG_LOW_NUM  = 999;
    localparam int DIAG_HIGH_NUM = 1001;

    // Register word index, taken from paddr[2].
    localparam logic REG_MATRIX_SIZE = 1'b0;

    typedef struct packed {
        logic [INDEX_W-1:0]        packed_index;
        logic signed [VALUE_W-1:0] left_value;
        logic signed [VALUE_W-1:0] right_value;
        logic                      last_element;
    } item_t;

    typedef struct packed {
        logic [SUM_W-1:0] diagonal_sum;
        logic [SUM_W-1:0] offdiagonal_sum;
        logic             diagonal_warning;
        logic             offdiagonal_warning;
    } result_t;

    typedef struct packed {
        logic [SUM_W-1:0] diag;
        logic [SUM_W-1:0] off;
    } sums_t;

endpackage

@@ sv/psic_engine.sv @@
// Element stores, product walk and the shared multiply-accumulate pipeline.
module psic_engine #(
    parameter int MAX_DIM = 16,
    parameter int DIM_W   = 5
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  psic_pkg::item_t    wr_item,
    input  logic               go,
    input  logic [DIM_W-1:0]   dim,
    output logic               done,
    output psic_pkg::sums_t    sums
);
    import psic_pkg::*;

    localparam int DEPTH  = MAX_DIM * (MAX_DIM + 1) / 2;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMP_W  = (ADDR_W > INDEX_W) ? ADDR_W : INDEX_W;
    localparam int ACC_W  = 2 * VALUE_W + ((MAX_DIM > 1) ? $clog2(MAX_DIM) : 0);
    localparam int TRI_W  = 2 * DIM_W + 1;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_ISSUE = 3'b010,
        S_DRAIN = 3'b100
    } state_t;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        logic diag;
    } tag_t;

    function automatic logic [ADDR_W-1:0] packed_pos(input logic [DIM_W-1:0] a,
                                                     input logic [DIM_W-1:0] b);
        logic [DIM_W-1:0] hi;
        logic [DIM_W-1:0] lo;
        logic [TRI_W-1:0] t;
        hi = (a >= b) ? a : b;
        lo = (a >= b) ? b : a;
        t  = (TRI_W'(hi) * (TRI_W'(hi) + TRI_W'(1))) >> 1;
        t  = t + TRI_W'(lo);
        return ADDR_W'(t);
    endfunction

    state_t state_reg, state_next;
    logic [DIM_W-1:0] n_reg, n_next;
    logic [DIM_W-1:0] r_reg, r_next;
    logic [DIM_W-1:0] c_reg, c_next;
    logic [DIM_W-1:0] k_reg, k_next;
    logic [DIM_W-1:0] n_last;

    logic [VALUE_W-1:0] left_mem  [DEPTH];
    logic [VALUE_W-1:0] right_mem [DEPTH];

    logic [CMP_W-1:0]  widx;
    logic              wr_ok;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr_l;
    logic [ADDR_W-1:0] raddr_r;

    logic signed [VALUE_W-1:0]   ldata_reg;
    logic signed [VALUE_W-1:0]   rdata_reg;
    logic signed [2*VALUE_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]     entry_reg;
    logic signed [ACC_W-1:0]     entry_base;
    logic [ACC_W-1:0]            entry_abs;
    logic [SUM_W-1:0]            mag_reg;
    logic [SUM_W:0]              diag_sum;
    logic [SUM_W:0]              off_sum;
    logic [SUM_W-1:0]            diag_acc_reg;
    logic [SUM_W-1:0]            off_acc_reg;

    tag_t tag1_reg, tag1_next;
    tag_t tag2_reg, tag3_reg, tag4_reg;
    logic pipe_busy;

    assign n_last    = n_reg - 1'b1;
    assign pipe_busy = tag1_reg.valid | tag2_reg.valid | tag3_reg.valid | tag4_reg.valid;
    assign done      = (state_reg == S_DRAIN) && !pipe_busy;
    assign sums      = '{diag: diag_acc_reg, off: off_acc_reg};

    // Walk row, column, then the inner index k, one product per cycle.
    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        r_next     = r_reg;
        c_next     = c_reg;
        k_next     = k_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (go)
                begin
                    n_next     = dim;
                    r_next     = '0;
                    c_next     = '0;
                    k_next     = '0;
                    state_next = (dim == '0) ? S_DRAIN : S_ISSUE;
                end
            end
            S_ISSUE:
            begin
                if (k_reg == n_last)
                begin
                    k_next = '0;
                    if (c_reg == n_last)
                    begin
                        c_next = '0;
                        if (r_reg == n_last)
                            state_next = S_DRAIN;
                        else
                            r_next = r_reg + 1'b1;
                    end
                    else
                    begin
                        c_next = c_reg + 1'b1;
                    end
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                if (!pipe_busy)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        tag1_next.valid = (state_reg == S_ISSUE);
        tag1_next.first = (k_reg == '0);
        tag1_next.last  = (k_reg == n_last);
        tag1_next.diag  = (r_reg == c_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            n_reg     <= '0;
            r_reg     <= '0;
            c_reg     <= '0;
            k_reg     <= '0;
            tag1_reg  <= '0;
            tag2_reg  <= '0;
            tag3_reg  <= '0;
            tag4_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            r_reg     <= r_next;
            c_reg     <= c_next;
            k_reg     <= k_next;
            tag1_reg  <= tag1_next;
            tag2_reg  <= tag1_reg;
            tag3_reg  <= tag2_reg;
            tag4_reg  <= '{valid: tag3_reg.valid & tag3_reg.last, first: 1'b0,
                           last: 1'b0, diag: tag3_reg.diag};
        end
    end

    assign widx    = CMP_W'(wr_item.packed_index);
    assign wr_ok   = wr_en && (widx < CMP_W'(DEPTH));
    assign waddr   = widx[ADDR_W-1:0];
    assign raddr_l = packed_pos(r_reg, k_reg);
    assign raddr_r = packed_pos(k_reg, c_reg);

    always_ff @(posedge clk)
    begin
        if (wr_ok)
        begin
            left_mem[waddr]  <= wr_item.left_value;
            right_mem[waddr] <= wr_item.right_value;
        end
        ldata_reg <= left_mem[raddr_l];
        rdata_reg <= right_mem[raddr_r];
    end

    // The entry sum is exact; its magnitude is truncated to Q24.24 afterwards.
    assign entry_base = tag2_reg.first ? '0 : entry_reg;
    assign entry_abs  = entry_reg[ACC_W-1] ? ACC_W'(-entry_reg) : ACC_W'(entry_reg);

    always_ff @(posedge clk)
    begin
        prod_reg  <= ldata_reg * rdata_reg;
        entry_reg <= entry_base + ACC_W'(prod_reg);
        mag_reg   <= SUM_W'(entry_abs[ACC_W-1:FRAC_BITS]);
    end

    assign diag_sum = {1'b0, diag_acc_reg} + {1'b0, mag_reg};
    assign off_sum  = {1'b0, off_acc_reg} + {1'b0, mag_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diag_acc_reg <= '0;
            off_acc_reg  <= '0;
        end
        else if (go)
        begin
            diag_acc_reg <= '0;
            off_acc_reg  <= '0;
        end
        else if (tag4_reg.valid)
        begin
            if (tag4_reg.diag)
                diag_acc_reg <= diag_sum[SUM_W] ? SUM_MAX : diag_sum[SUM_W-1:0];
            else
                off_acc_reg <= off_sum[SUM_W] ? SUM_MAX : off_sum[SUM_W-1:0];
        end
    end

`ifndef SYNTH
    a_go_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        go |-> state_reg == S_IDLE)
        else $error("check started while the walk was active");

    a_accum_while_active: assert property (@(posedge clk) disable iff (!rst_n)
        tag4_reg.valid |-> state_reg != S_IDLE)
        else $error("entry accumulated after the walk finished");

    a_done_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (state_reg == S_IDLE) && !tag1_reg.valid)
        else $error("walk did not return to idle after done");
`endif

endmodule

@@ sv/packed_symmetric_inverse_check.sv @@
// Top level: register port, command handshake and the final bound checks.
//
// Load both matrices one packed element per cycle: each word with start high and
// busy low is taken at once. The word marked last starts the check, and busy then
// stays high while it runs: a single 32x32 multiplier issues one product per cycle
// while a sequencer walks row, column and inner index, and a short pipeline finishes
// each entry. The result word appears on result with result_valid high for exactly
// one cycle; the receiver cannot stall it, so it must take the word in that cycle.
// Every store entry that a check reads must have been loaded since reset.
// matrix_size must be written only while busy is low; the block does not enforce it.
module packed_symmetric_inverse_check #(
    parameter int MAX_DIM = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  psic_pkg::item_t   item,
    output logic              busy,
    output logic              result_valid,
    output psic_pkg::result_t result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import psic_pkg::*;

    localparam int DIM_W = $clog2(MAX_DIM + 1);

    typedef enum logic [2:0] {
        T_IDLE  = 3'b001,
        T_RUN   = 3'b010,
        T_CHECK = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic [SIZE_W-1:0]  matrix_size_reg;
    logic [DIM_W-1:0]   n_eff;
    logic               accept;
    logic               eng_go;
    logic               eng_done;
    sums_t              eng_sums;
    logic [SUM_W-1:0]   diag_reg;
    logic [SUM_W-1:0]   off_reg;
    logic [CHECK_W-1:0] scaled_reg;
    logic [CHECK_W-1:0] low_bound_reg;
    logic [CHECK_W-1:0] high_bound_reg;
    result_t            result_reg;
    logic               result_valid_reg;
    logic               cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_MATRIX_SIZE);
    assign prdata    = (paddr[2] == REG_MATRIX_SIZE) ? 32'(matrix_size_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            matrix_size_reg <= MATRIX_SIZE_RESET;
        else if (cfg_write)
            matrix_size_reg <= pwdata[SIZE_W-1:0];
    end

    always_comb
    begin
        if (int'(matrix_size_reg) > MAX_DIM)
            n_eff = DIM_W'(MAX_DIM);
        else
            n_eff = DIM_W'(matrix_size_reg);
    end

    assign busy   = (state_reg != T_IDLE);
    assign accept = start && !busy;
    assign eng_go = accept && item.last_element;

    psic_engine #(
        .MAX_DIM (MAX_DIM),
        .DIM_W   (DIM_W)
    ) u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept),
        .wr_item (item),
        .go      (eng_go),
        .dim     (n_eff),
        .done    (eng_done),
        .sums    (eng_sums)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            T_IDLE:
            begin
                if (eng_go)
                    state_next = T_RUN;
            end
            T_RUN:
            begin
                if (eng_done)
                    state_next = T_CHECK;
            end
            T_CHECK:
            begin
                state_next = T_IDLE;
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= T_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= (state_reg == T_CHECK);
        end
    end

    // Bounds are compared scaled by 1000 so that they stay exact.
    always_ff @(posedge clk)
    begin
        if (state_reg == T_RUN && eng_done)
        begin
            diag_reg       <= eng_sums.diag;
            off_reg        <= eng_sums.off;
            scaled_reg     <= CHECK_W'(eng_sums.diag) * CHECK_W'(DIAG_SCALE);
            low_bound_reg  <= (CHECK_W'(n_eff) * CHECK_W'(DIAG_LOW_NUM)) << FRAC_BITS;
            high_bound_reg <= (CHECK_W'(n_eff) * CHECK_W'(DIAG_HIGH_NUM)) << FRAC_BITS;
        end
        if (state_reg == T_CHECK)
        begin
            result_reg.diagonal_sum        <= diag_reg;
            result_reg.offdiagonal_sum     <= off_reg;
            result_reg.diagonal_warning    <= (scaled_reg < low_bound_reg) ||
                                              (scaled_reg > high_bound_reg);
            result_reg.offdiagonal_warning <= (off_reg > OFF_LIMIT);
        end
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

`ifndef SYNTH
    a_result_after_check: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(state_reg) == T_CHECK)
        else $error("result word without a preceding check");

    a_done_while_running: assert property (@(posedge clk) disable iff (!rst_n)
        eng_done |-> state_reg == T_RUN)
        else $error("engine finished while no check was running");

    a_last_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.last_element) |=> busy)
        else $error("last word did not start a check");
`endif

endmodule

@@ sim/inverse_check_scoreboard.sv @@
// Scoreboard for the packed symmetric inverse check: predicts each result word and compares.
module inverse_check_scoreboard #(
    parameter int MAX_DIM = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  psic_pkg::item_t   item,
    input  logic              busy,
    input  logic              result_valid,
    input  psic_pkg::result_t result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    input  logic [31:0]       prdata,
    input  logic              pready,
    output int                errors,
    output int                pending
);
    import psic_pkg::*;

    localparam int DEPTH = MAX_DIM * (MAX_DIM + 1) / 2;
    localparam longint unsigned UNITY_Q = 64'd1 << FRAC_BITS;

    logic signed [VALUE_W-1:0] left_mem [DEPTH];
    logic signed [VALUE_W-1:0] right_mem [DEPTH];
    logic [SIZE_W-1:0]         size_reg;
    result_t                   awaited_sums [$];
    int                        error_count = 0;
    int                        pending_count = 0;

    assign errors  = error_count;
    assign pending = pending_count;

    // Elements below the diagonal live at the mirrored packed position.
    function automatic int tri_pos(int row, int col);
        return (col >= row) ? col * (col + 1) / 2 + row : row * (row + 1) / 2 + col;
    endfunction

    function automatic longint unsigned sat_sum(longint unsigned acc, longint unsigned add);
        return (acc + add > SUM_MAX) ? SUM_MAX : acc + add;
    endfunction

    function automatic result_t product_sums(int dim);
        logic signed [71:0] entry;
        logic [71:0]        magnitude;
        longint             prod;
        longint unsigned    share;
        longint unsigned    diag_total;
        longint unsigned    off_total;
        result_t            res;
        diag_total = 0;
        off_total  = 0;
        for (int r = 0; r < dim; r++)
        begin
            for (int c = 0; c < dim; c++)
            begin
                entry = '0;
                for (int k = 0; k < dim; k++)
                begin
                    prod  = longint'(left_mem[tri_pos(r, k)]) * longint'(right_mem[tri_pos(k, c)]);
                    entry = entry + prod;
                end
                // Truncating the magnitude is truncation toward zero.
                magnitude = entry[71] ? -entry : entry;
                share = 64'(magnitude >> FRAC_BITS);
                if (r == c)
                    diag_total = sat_sum(diag_total, share);
                else
                    off_total = sat_sum(off_total, share);
            end
        end
        res.diagonal_sum    = diag_total[SUM_W-1:0];
        res.offdiagonal_sum = off_total[SUM_W-1:0];
        res.diagonal_warning =
            (diag_total * DIAG_SCALE < longint'(DIAG_LOW_NUM * dim) * UNITY_Q) ||
            (diag_total * DIAG_SCALE > longint'(DIAG_HIGH_NUM * dim) * UNITY_Q);
        res.offdiagonal_warning = (off_total * 10000 > UNITY_Q);
        return res;
    endfunction

    task automatic compare_field(input string what, input longint unsigned want,
                                 input longint unsigned got);
        if (want != got)
        begin
            error_count++;
            $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        int      dim;
        result_t want;
        if (!rst_n)
        begin
            size_reg = MATRIX_SIZE_RESET;
        end
        else
        begin
            if (result_valid)
            begin
                if (awaited_sums.size() == 0)
                begin
                    error_count++;
                    $display("%0t: result word with none expected, expected nothing, got %h",
                             $time, result);
                end
                else
                begin
                    want = awaited_sums.pop_front();
                    compare_field("diagonal_sum", want.diagonal_sum, result.diagonal_sum);
                    compare_field("offdiagonal_sum", want.offdiagonal_sum,
                                  result.offdiagonal_sum);
                    compare_field("diagonal_warning", want.diagonal_warning,
                                  result.diagonal_warning);
                    compare_field("offdiagonal_warning", want.offdiagonal_warning,
                                  result.offdiagonal_warning);
                end
            end

            if (psel && penable && pready && paddr[2] == REG_MATRIX_SIZE)
            begin
                if (pwrite)
                    size_reg = pwdata[SIZE_W-1:0];
                else
                    compare_field("prdata", 32'(size_reg), prdata);
            end

            if (start && !busy)
            begin
                if (item.packed_index < DEPTH)
                begin
                    left_mem[item.packed_index]  = item.left_value;
                    right_mem[item.packed_index] = item.right_value;
                end
                if (item.last_element)
                begin
                    dim = (size_reg > MAX_DIM) ? MAX_DIM : int'(size_reg);
                    awaited_sums.push_back(product_sums(dim));
                end
            end
            pending_count = awaited_sums.size();
        end
    end

endmodule

@@ sim/packed_symmetric_inverse_check_tb.sv @@
// Testbench top for the packed symmetric inverse check: stimulus, timeout and verdict.
module packed_symmetric_inverse_check_tb;
    import psic_pkg::*;

    localparam int MAX_DIM     = 16;
    localparam int DEPTH       = MAX_DIM * (MAX_DIM + 1) / 2;
    localparam int ITEM_GOAL   = 1850;
    localparam int CYCLE_LIMIT = 2_000_000;

    localparam logic [VALUE_W-1:0] UNITY    = 32'h0100_0000;
    localparam logic [VALUE_W-1:0] MOST_NEG = 32'h8000_0000;
    localparam logic [VALUE_W-1:0] MOST_POS = 32'h7FFF_FFFF;

    logic        clk;
    logic        rst_n;
    logic        start;
    item_t       item;
    logic        busy;
    logic        result_valid;
    result_t     result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int errors;
    int pending;
    int cycles = 0;
    int burst_left;
    int counted_items;
    int cur_size;

    packed_symmetric_inverse_check #(.MAX_DIM(MAX_DIM)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .item         (item),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    inverse_check_scoreboard #(.MAX_DIM(MAX_DIM)) scoreboard (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .item         (item),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .errors       (errors),
        .pending      (pending)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic int tri_index(int row, int col);
        return col * (col + 1) / 2 + row;
    endfunction

    // Sends one word; the sender works in bursts separated by idle gaps.
    task automatic send_word(input int idx, input logic [VALUE_W-1:0] lv,
                             input logic [VALUE_W-1:0] rv, input logic lst);
        item_t w;
        int    gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 40) : $urandom_range(1, 5);
            start <= 1'b0;
            repeat (gap) @(negedge clk);
            burst_left = $urandom_range(1, 48);
        end
        burst_left--;
        w.packed_index = idx[INDEX_W-1:0];
        w.left_value   = lv;
        w.right_value  = rv;
        w.last_element = lst;
        item  <= w;
        start <= 1'b1;
        do @(posedge clk); while (busy);
        @(negedge clk);
        counted_items++;
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (pending != 0 || busy) @(negedge clk);
        repeat (4) @(negedge clk);
        while (busy) @(negedge clk);
    endtask

    // Writes the size register, then reads it back for the scoreboard to check.
    task automatic set_size(input logic [31:0] value);
        wait_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_MATRIX_SIZE, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        cur_size = int'(value[SIZE_W-1:0]);
    endtask

    task automatic pick_values(input int mode, input logic on_diag, input int amp,
                               input int dev, output logic [VALUE_W-1:0] lv,
                               output logic [VALUE_W-1:0] rv);
        case (mode)
            0, 1:
            begin
                lv = $urandom;
                rv = $urandom;
            end
            2:
            begin
                // Mostly the most negative value, so that products pile up to saturation.
                lv = ($urandom_range(0, 3) != 0) ? MOST_NEG : MOST_POS;
                rv = ($urandom_range(0, 3) != 0) ? MOST_NEG : MOST_POS;
                if ($urandom_range(0, 7) == 0)
                    lv = lv ^ 32'd1;
            end
            3:
            begin
                lv = $urandom_range(0, 32'h20_0000) - 32'h10_0000;
                rv = $urandom_range(0, 32'h20_0000) - 32'h10_0000;
            end
            default:
            begin
                // Nearly an identity pair, aimed at both warning thresholds.
                if (on_diag)
                begin
                    lv = UNITY + $urandom_range(0, 2 * dev) - dev;
                    rv = ($urandom_range(0, 3) == 0) ? UNITY + $urandom_range(0, 64) - 32 : UNITY;
                end
                else
                begin
                    lv = $urandom_range(0, 2 * amp) - amp;
                    rv = $urandom_range(0, 2 * amp) - amp;
                end
            end
        endcase
    endtask

    task automatic run_random_set();
        int pick;
        int dim;
        int words;
        int mode;
        int shape;
        int amp;
        int dev;
        int pos;
        int prefix;
        logic [VALUE_W-1:0] lv;
        logic [VALUE_W-1:0] rv;
        pick = $urandom_range(0, 19);
        if ($urandom_range(0, 3) != 0)
        begin
            if (pick == 0)
                set_size(0);
            else if (pick == 1)
                set_size($urandom_range(17, 31));
            else if (pick == 2)
                set_size(MAX_DIM);
            else if (pick <= 6)
                set_size($urandom_range(7, 15));
            else
                set_size($urandom_range(1, 6));
        end
        dim   = (cur_size > MAX_DIM) ? MAX_DIM : cur_size;
        words = dim * (dim + 1) / 2;
        mode  = $urandom_range(0, 9);
        if (dim >= 12 && $urandom_range(0, 2) == 0)
            mode = 2;
        amp   = $urandom_range(0, 3000 / (dim * dim + 1) + 2);
        dev   = $urandom_range(0, 40000);
        shape = $urandom_range(0, 9);

        if (shape <= 7 && words > 0)
        begin
            for (int col = 0; col < dim; col++)
            begin
                for (int row = 0; row <= col; row++)
                begin
                    pos = tri_index(row, col);
                    pick_values(mode, row == col, amp, dev, lv, rv);
                    if ($urandom_range(0, 29) == 0)
                        send_word($urandom_range(DEPTH, 255), $urandom, $urandom, 1'b0);
                    send_word(pos, lv, rv, pos == words - 1);
                end
            end
        end
        else if (shape == 8 || words == 0)
        begin
            // A load cut short, closed by a last word at an arbitrary position.
            prefix = $urandom_range(0, words);
            for (int p = 0; p < prefix; p++)
            begin
                pick_values(mode, $urandom_range(0, 1), amp, dev, lv, rv);
                send_word(p, lv, rv, 1'b0);
            end
            send_word($urandom_range(0, 255), $urandom, $urandom, 1'b1);
        end
        else
        begin
            repeat ($urandom_range(1, 12))
                send_word($urandom_range(0, 255), $urandom, $urandom, 1'b0);
            send_word($urandom_range(0, 255), $urandom, $urandom, 1'b1);
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        start      = 1'b0;
        item       = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        burst_left = 0;
        cur_size   = int'(MATRIX_SIZE_RESET);
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Fill both stores with the identity and check at the reset size.
        for (int col = 0; col < MAX_DIM; col++)
        begin
            for (int row = 0; row <= col; row++)
            begin
                send_word(tri_index(row, col), (row == col) ? UNITY : '0,
                          (row == col) ? UNITY : '0, col == MAX_DIM - 1 && row == col);
            end
        end

        // Positions past the store are dropped, but a last word there still runs the check.
        send_word(0, MOST_POS, MOST_NEG, 1'b0);
        send_word(DEPTH, 32'h1234_5678, 32'h8765_4321, 1'b0);
        send_word(255, MOST_NEG, MOST_POS, 1'b1);

        set_size(1);
        send_word(0, MOST_NEG, MOST_NEG, 1'b1);
        send_word(0, MOST_POS, MOST_POS, 1'b1);
        send_word(0, 32'hFFFF_FFFF, 32'd3, 1'b1);
        // Diagonal sum just either side of both bounds.
        send_word(0, 32'd16760438, UNITY, 1'b1);
        send_word(0, 32'd16760439, UNITY, 1'b1);
        send_word(0, 32'd16793993, UNITY, 1'b1);
        send_word(0, 32'd16793994, UNITY, 1'b1);

        set_size(0);
        send_word(5, $urandom, $urandom, 1'b1);

        // Off-diagonal sum is twice the corner value: 1678 warns, 1676 does not.
        set_size(2);
        send_word(0, UNITY, UNITY, 1'b0);
        send_word(2, UNITY, UNITY, 1'b0);
        send_word(1, 32'd839, '0, 1'b1);
        send_word(1, 32'd838, '0, 1'b1);

        // Bits above the register width are ignored, leaving a size of 16.
        set_size(32'hFFFF_FFF0);
        send_word(1, 32'h100, '0, 1'b1);
        set_size(31);
        send_word(DEPTH - 1, MOST_NEG, MOST_POS, 1'b1);

        counted_items = 0;
        while (counted_items < ITEM_GOAL)
            run_random_set();

        wait_idle();
        repeat (20) @(negedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
